[hw/rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising clock, ignored while reset is high.
`define BSM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Condition that must never be true on a rising clock outside reset.
`define BSM_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);

`endif

[hw/rtl/bsm_pkg.sv]
package bsm_pkg;

   localparam int COORD_W  = 32;
   localparam int RADIUS_W = 31;
   localparam int CASE_W   = 2;
   localparam int AXES     = 3;
   localparam int MAG_W    = COORD_W;
   localparam int SQ_W     = 2 * MAG_W;
   // The distance is below 2^34 because the squared distance is below 3 * 2^64.
   localparam int ROOT_W   = 34;
   localparam int REM_W    = 2 * ROOT_W;
   localparam int NUM_W    = ROOT_W + 2;
   localparam int PROD_W   = MAG_W + NUM_W;
   localparam int QUOT_W   = MAG_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W   = $clog2(QUEUE_DEPTH);

   localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;

   localparam logic [CASE_W-1:0] CASE_GENERAL = 2'd0;
   localparam logic [CASE_W-1:0] CASE_FIRST   = 2'd1;
   localparam logic [CASE_W-1:0] CASE_SECOND  = 2'd2;
   localparam logic [CASE_W-1:0] CASE_SAT     = 2'd3;

   typedef logic [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type [AXES-1:0] c1;
      coord_type [AXES-1:0] c2;
      logic [RADIUS_W-1:0]  r1;
      logic [RADIUS_W-1:0]  r2;
   } pair_type;

   typedef struct packed {
      pair_type                    pair;
      logic [AXES-1:0][MAG_W-1:0]  mag;
      logic [AXES-1:0][SQ_W-1:0]   sq;
      logic [REM_W-1:0]            rem;
      logic [ROOT_W-1:0]           root;
   } front_type;

   typedef struct packed {
      pair_type             pair;
      logic [ROOT_W-1:0]    center_dist;
      logic [RADIUS_W-1:0]  radius;
      logic [CASE_W-1:0]    mcase;
   } task_type;

   typedef struct packed {
      pair_type                     pair;
      logic [RADIUS_W-1:0]          radius;
      logic [CASE_W-1:0]            mcase;
      logic [AXES-1:0]              neg;
      logic [AXES-1:0][MAG_W-1:0]   mag;
      logic [NUM_W-1:0]             num;
      logic [NUM_W-1:0]             den;
      logic [AXES-1:0][PROD_W-1:0]  work;
   } back_type;

   typedef struct packed {
      coord_type [AXES-1:0] center;
      logic [RADIUS_W-1:0]  radius;
      logic [CASE_W-1:0]    mcase;
   } result_type;

   // Sign-extended difference b - a.
   function automatic logic [COORD_W:0] coord_diff(input coord_type a, input coord_type b);
      coord_diff = {b[COORD_W-1], b} - {a[COORD_W-1], a};
   endfunction

   // Magnitude of a sign-extended difference; it always fits COORD_W bits.
   function automatic logic [MAG_W-1:0] magnitude(input logic [COORD_W:0] v);
      logic [COORD_W:0] n;
      n = -v;
      magnitude = v[COORD_W] ? n[MAG_W-1:0] : v[MAG_W-1:0];
   endfunction

endpackage

[hw/rtl/bsm_req_if.sv]
interface bsm_req_if;
   logic valid;
   logic ready;
   logic signed [bsm_pkg::COORD_W-1:0] first_center_x;
   logic signed [bsm_pkg::COORD_W-1:0] first_center_y;
   logic signed [bsm_pkg::COORD_W-1:0] first_center_z;
   logic [bsm_pkg::RADIUS_W-1:0]       first_radius;
   logic signed [bsm_pkg::COORD_W-1:0] second_center_x;
   logic signed [bsm_pkg::COORD_W-1:0] second_center_y;
   logic signed [bsm_pkg::COORD_W-1:0] second_center_z;
   logic [bsm_pkg::RADIUS_W-1:0]       second_radius;

   modport source (
      output valid, first_center_x, first_center_y, first_center_z, first_radius,
             second_center_x, second_center_y, second_center_z, second_radius,
      input  ready
   );
   modport sink (
      input  valid, first_center_x, first_center_y, first_center_z, first_radius,
             second_center_x, second_center_y, second_center_z, second_radius,
      output ready
   );
endinterface

[hw/rtl/bsm_rsp_if.sv]
interface bsm_rsp_if;
   logic valid;
   logic ready;
   logic signed [bsm_pkg::COORD_W-1:0] merged_center_x;
   logic signed [bsm_pkg::COORD_W-1:0] merged_center_y;
   logic signed [bsm_pkg::COORD_W-1:0] merged_center_z;
   logic [bsm_pkg::RADIUS_W-1:0]       merged_radius;
   logic [bsm_pkg::CASE_W-1:0]         merge_case;

   modport source (
      output valid, merged_center_x, merged_center_y, merged_center_z, merged_radius,
             merge_case,
      input  ready
   );
   modport sink (
      input  valid, merged_center_x, merged_center_y, merged_center_z, merged_radius,
             merge_case,
      output ready
   );
endinterface

[hw/rtl/bsm_queue.sv]
`include "assert_macros.svh"

module bsm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  bsm_pkg::task_type  in_data,
   output logic               in_full,
   output logic               out_valid,
   output bsm_pkg::task_type  out_data,
   input  logic               out_pop
);

   bsm_pkg::task_type              mem_ff [bsm_pkg::QUEUE_DEPTH];
   logic [bsm_pkg::QPTR_W-1:0]     wr_ff, wr_in;
   logic [bsm_pkg::QPTR_W-1:0]     rd_ff, rd_in;
   logic [bsm_pkg::QPTR_W:0]       count_ff, count_in;
   logic                           push;

   // A transaction enters only while a slot is free.
   assign in_full   = (count_ff == (bsm_pkg::QPTR_W+1)'(bsm_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ff];
   assign push      = in_valid && !in_full;

   // Pointers wrap at the queue depth.
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == bsm_pkg::QPTR_W'(bsm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (out_pop) begin
         rd_in = (rd_ff == bsm_pkg::QPTR_W'(bsm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !out_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && out_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_data;
      end
   end

   `BSM_ASSERT(queue_pop_nonempty, out_pop |-> (count_ff != '0), "pop from empty queue")
   `BSM_ASSERT_NEVER(queue_overfill,
      count_ff > (bsm_pkg::QPTR_W+1)'(bsm_pkg::QUEUE_DEPTH), "queue count overflow")

endmodule

[hw/rtl/bsm_front.sv]
`include "assert_macros.svh"

module bsm_front (
   input  logic               clock,
   input  logic               reset,
   bsm_req_if.sink            req,
   output bsm_pkg::task_type  task_out,
   output logic               task_valid,
   input  logic               task_full
);

   // Stages: difference magnitudes, squares, sum, one stage per root bit.
   localparam int STAGES = bsm_pkg::ROOT_W + 3;
   localparam int TASK   = STAGES;

   bsm_pkg::front_type   st_ff [STAGES];
   bsm_pkg::front_type   st_in [STAGES];
   bsm_pkg::task_type    task_ff, task_in;
   logic [STAGES:0]      fv_ff, fv_in;
   logic                 advance;

   // The whole front moves together unless its last transaction is held by the queue.
   assign advance    = !fv_ff[TASK] || !task_full;
   assign req.ready  = advance;
   assign task_valid = fv_ff[TASK];
   assign task_out   = task_ff;
   assign fv_in      = {fv_ff[STAGES-1:0], req.valid};

   always_comb begin
      logic [bsm_pkg::REM_W-1:0]    inc;
      logic [bsm_pkg::NUM_W-1:0]    d_ext;
      logic [bsm_pkg::NUM_W-1:0]    r1_ext;
      logic [bsm_pkg::NUM_W-1:0]    r2_ext;
      logic [bsm_pkg::NUM_W-1:0]    rad;
      int                           b;

      // Capture the pair and the per-axis distance magnitudes.
      st_in[0] = '0;
      st_in[0].pair.c1[0] = req.first_center_x;
      st_in[0].pair.c1[1] = req.first_center_y;
      st_in[0].pair.c1[2] = req.first_center_z;
      st_in[0].pair.c2[0] = req.second_center_x;
      st_in[0].pair.c2[1] = req.second_center_y;
      st_in[0].pair.c2[2] = req.second_center_z;
      st_in[0].pair.r1    = req.first_radius;
      st_in[0].pair.r2    = req.second_radius;
      for (int a = 0; a < bsm_pkg::AXES; a++) begin
         st_in[0].mag[a] = bsm_pkg::magnitude(
            bsm_pkg::coord_diff(st_in[0].pair.c1[a], st_in[0].pair.c2[a]));
      end

      // One multiplier per axis.
      st_in[1] = st_ff[0];
      for (int a = 0; a < bsm_pkg::AXES; a++) begin
         st_in[1].sq[a] = bsm_pkg::SQ_W'(st_ff[0].mag[a]) * bsm_pkg::SQ_W'(st_ff[0].mag[a]);
      end

      // Squared distance.
      st_in[2]      = st_ff[1];
      st_in[2].rem  = bsm_pkg::REM_W'(st_ff[1].sq[0]) + bsm_pkg::REM_W'(st_ff[1].sq[1])
                    + bsm_pkg::REM_W'(st_ff[1].sq[2]);
      st_in[2].root = '0;

      // Digit-by-digit square root, one result bit per stage from the top.
      for (int k = 0; k < bsm_pkg::ROOT_W; k++) begin
         b   = bsm_pkg::ROOT_W - 1 - k;
         inc = (bsm_pkg::REM_W'(st_ff[2+k].root) << (b + 1))
             | (bsm_pkg::REM_W'(1) << (2 * b));
         st_in[3+k] = st_ff[2+k];
         if (st_ff[2+k].rem >= inc) begin
            st_in[3+k].rem  = st_ff[2+k].rem - inc;
            st_in[3+k].root = st_ff[2+k].root | (bsm_pkg::ROOT_W'(1) << b);
         end
      end

      // Classify: containment first, then the general merge with saturation.
      d_ext  = bsm_pkg::NUM_W'(st_ff[STAGES-1].root);
      r1_ext = bsm_pkg::NUM_W'(st_ff[STAGES-1].pair.r1);
      r2_ext = bsm_pkg::NUM_W'(st_ff[STAGES-1].pair.r2);
      rad    = (d_ext + r1_ext + r2_ext) >> 1;
      task_in.pair        = st_ff[STAGES-1].pair;
      task_in.center_dist = st_ff[STAGES-1].root;
      if (d_ext + r2_ext <= r1_ext) begin
         task_in.radius = st_ff[STAGES-1].pair.r1;
         task_in.mcase  = bsm_pkg::CASE_FIRST;
      end else if (d_ext + r1_ext <= r2_ext) begin
         task_in.radius = st_ff[STAGES-1].pair.r2;
         task_in.mcase  = bsm_pkg::CASE_SECOND;
      end else if (rad > bsm_pkg::NUM_W'(bsm_pkg::RADIUS_MAX)) begin
         task_in.radius = bsm_pkg::RADIUS_MAX;
         task_in.mcase  = bsm_pkg::CASE_SAT;
      end else begin
         task_in.radius = rad[bsm_pkg::RADIUS_W-1:0];
         task_in.mcase  = bsm_pkg::CASE_GENERAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else if (advance) begin
         fv_ff <= fv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff   <= st_in;
         task_ff <= task_in;
      end
   end

   // A general merge always has distinct centers, so the later divide never sees zero.
   `BSM_ASSERT(front_general_nonzero_dist,
      (fv_ff[TASK] && task_ff.mcase != bsm_pkg::CASE_FIRST &&
       task_ff.mcase != bsm_pkg::CASE_SECOND) |-> (task_ff.center_dist != '0),
      "general merge with zero center distance")

endmodule

[hw/rtl/bsm_back.sv]
`include "assert_macros.svh"

module bsm_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               task_valid,
   input  bsm_pkg::task_type  task_in,
   output logic               task_pop,
   bsm_rsp_if.source          rsp
);

   // Stages: setup, product, one stage per quotient bit, then the output register.
   localparam int STAGES = bsm_pkg::QUOT_W + 2;
   localparam int OUT    = STAGES;
   localparam int TRIAL_W = bsm_pkg::NUM_W + 1;

   bsm_pkg::back_type    bk_ff [STAGES];
   bsm_pkg::back_type    bk_in [STAGES];
   bsm_pkg::result_type  res_ff, res_in;
   logic [STAGES:0]      bv_ff, bv_in;
   logic                 advance;

   // The back moves together unless the output register is held by the sink.
   assign advance  = !bv_ff[OUT] || rsp.ready;
   assign task_pop = advance && task_valid;
   assign bv_in    = {bv_ff[STAGES-1:0], task_valid};

   assign rsp.valid           = bv_ff[OUT];
   assign rsp.merged_center_x = res_ff.center[0];
   assign rsp.merged_center_y = res_ff.center[1];
   assign rsp.merged_center_z = res_ff.center[2];
   assign rsp.merged_radius   = res_ff.radius;
   assign rsp.merge_case      = res_ff.mcase;

   always_comb begin
      logic [bsm_pkg::COORD_W:0]   diff;
      logic [TRIAL_W-1:0]          trial;
      logic                        qbit;
      logic [bsm_pkg::QUOT_W-1:0]  quot;

      // Setup: offset direction, numerator d + r2 - r1 and divisor 2d.
      bk_in[0]        = '0;
      bk_in[0].pair   = task_in.pair;
      bk_in[0].radius = task_in.radius;
      bk_in[0].mcase  = task_in.mcase;
      bk_in[0].num    = bsm_pkg::NUM_W'(task_in.center_dist)
                      + bsm_pkg::NUM_W'(task_in.pair.r2)
                      - bsm_pkg::NUM_W'(task_in.pair.r1);
      bk_in[0].den    = bsm_pkg::NUM_W'(task_in.center_dist) << 1;
      for (int a = 0; a < bsm_pkg::AXES; a++) begin
         diff = bsm_pkg::coord_diff(task_in.pair.c1[a], task_in.pair.c2[a]);
         bk_in[0].neg[a] = diff[bsm_pkg::COORD_W];
         bk_in[0].mag[a] = bsm_pkg::magnitude(diff);
      end

      // Dividend per axis.
      bk_in[1] = bk_ff[0];
      for (int a = 0; a < bsm_pkg::AXES; a++) begin
         bk_in[1].work[a] = bsm_pkg::PROD_W'(bk_ff[0].mag[a]) * bsm_pkg::PROD_W'(bk_ff[0].num);
      end

      // Restoring division; the quotient bits shift in at the bottom of each word.
      for (int k = 0; k < bsm_pkg::QUOT_W; k++) begin
         bk_in[2+k] = bk_ff[1+k];
         for (int a = 0; a < bsm_pkg::AXES; a++) begin
            trial = bk_ff[1+k].work[a][bsm_pkg::PROD_W-1:bsm_pkg::QUOT_W-1];
            qbit  = (trial >= {1'b0, bk_ff[1+k].den});
            if (qbit) begin
               trial = trial - {1'b0, bk_ff[1+k].den};
            end
            bk_in[2+k].work[a] = {trial[bsm_pkg::NUM_W-1:0],
                                  bk_ff[1+k].work[a][bsm_pkg::QUOT_W-2:0], qbit};
         end
      end

      // Place the center, or return the containing sphere.
      res_in.radius = bk_ff[STAGES-1].radius;
      res_in.mcase  = bk_ff[STAGES-1].mcase;
      for (int a = 0; a < bsm_pkg::AXES; a++) begin
         quot = bk_ff[STAGES-1].work[a][bsm_pkg::QUOT_W-1:0];
         case (bk_ff[STAGES-1].mcase)
            bsm_pkg::CASE_FIRST:  res_in.center[a] = bk_ff[STAGES-1].pair.c1[a];
            bsm_pkg::CASE_SECOND: res_in.center[a] = bk_ff[STAGES-1].pair.c2[a];
            default: begin
               res_in.center[a] = bk_ff[STAGES-1].neg[a] ?
                  bk_ff[STAGES-1].pair.c1[a] - quot : bk_ff[STAGES-1].pair.c1[a] + quot;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff <= '0;
      end else if (advance) begin
         bv_ff <= bv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         bk_ff  <= bk_in;
         res_ff <= res_in;
      end
   end

   `BSM_ASSERT(back_sat_radius,
      (bv_ff[OUT] && res_ff.mcase == bsm_pkg::CASE_SAT) |-> (res_ff.radius == bsm_pkg::RADIUS_MAX),
      "saturated result without maximum radius")

endmodule

[hw/rtl/bounding_sphere_merge_core.sv]
// Bounding sphere merge: each transaction on req_chan carries two spheres (signed fixed-point
// centers, unsigned radii) and produces one transaction on rsp_chan with the smallest
// enclosing sphere and a case code (general, first contains second, second contains first,
// radius saturated). A new pair is accepted every cycle while results keep draining. The
// result passes the square root pipeline (one stage per distance bit, 34 stages plus four),
// the two-entry queue and the divider pipeline (one stage per quotient bit, 32 stages plus
// three). Either half stalls on its own when its neighbor is not ready.
module bounding_sphere_merge_core (
   input  logic        clock,
   input  logic        reset,
   bsm_req_if.sink     req_chan,
   bsm_rsp_if.source   rsp_chan
);

   bsm_pkg::task_type  fr_task;
   logic               fr_valid;
   bsm_pkg::task_type  q_task;
   logic               q_full;
   logic               q_valid;
   logic               bk_pop;

   // Distance and classification.
   bsm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .task_out   (fr_task),
      .task_valid (fr_valid),
      .task_full  (q_full)
   );

   // Decoupling queue.
   bsm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_data   (fr_task),
      .in_full   (q_full),
      .out_valid (q_valid),
      .out_data  (q_task),
      .out_pop   (bk_pop)
   );

   // Center placement and output register.
   bsm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .task_valid (q_valid),
      .task_in    (q_task),
      .task_pop   (bk_pop),
      .rsp        (rsp_chan)
   );

endmodule

[tb/sv/bounding_sphere_merge_core_tb.sv]
`timescale 1ns / 1ps

module bounding_sphere_merge_core_tb;

   localparam int RANDOM_PAIRS = 730;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      logic signed [bsm_pkg::COORD_W-1:0] c1 [bsm_pkg::AXES];
      logic signed [bsm_pkg::COORD_W-1:0] c2 [bsm_pkg::AXES];
      logic [bsm_pkg::RADIUS_W-1:0]       r1;
      logic [bsm_pkg::RADIUS_W-1:0]       r2;
   } sphere_pair_type;

   typedef struct {
      logic signed [bsm_pkg::COORD_W-1:0] center [bsm_pkg::AXES];
      logic [bsm_pkg::RADIUS_W-1:0]       radius;
      logic [bsm_pkg::CASE_W-1:0]         mcase;
   } enclosing_type;

   // One row of the directed stimulus; the expected sphere is typed in where known.
   typedef struct {
      sphere_pair_type pair;
      bit              known;
      enclosing_type   sphere;
   } directed_row_type;

   logic clock;
   logic reset;

   bsm_req_if req_chan ();
   bsm_rsp_if rsp_chan ();

   bounding_sphere_merge_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   enclosing_type expected_spheres [$];
   directed_row_type directed_rows [$];
   int mismatch_count;
   int pairs_accepted;
   int spheres_checked;
   int case_seen [4];
   bit hold_requested;
   bit no_idle;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Enclosing sphere of two spheres, computed on wide integers with the root and offsets rounded down.
   function automatic enclosing_type merge_spheres(input sphere_pair_type p);
      enclosing_type res;
      logic signed [bsm_pkg::COORD_W:0] dc [bsm_pkg::AXES];
      logic [bsm_pkg::COORD_W:0] mag;
      logic [71:0] dist_sq;
      logic [71:0] trial_sq;
      logic [bsm_pkg::ROOT_W-1:0] root_dist;
      logic [bsm_pkg::ROOT_W-1:0] trial;
      logic [35:0] span_num;
      logic [35:0] span_den;
      logic [35:0] rad;
      logic [71:0] offset;
      dist_sq = '0;
      for (int a = 0; a < bsm_pkg::AXES; a++) begin
         dc[a] = $signed({p.c2[a][bsm_pkg::COORD_W-1], p.c2[a]})
               - $signed({p.c1[a][bsm_pkg::COORD_W-1], p.c1[a]});
         mag = dc[a][bsm_pkg::COORD_W] ? -dc[a] : dc[a];
         dist_sq += 72'(mag) * 72'(mag);
      end
      root_dist = '0;
      for (int b = bsm_pkg::ROOT_W - 1; b >= 0; b--) begin
         trial = root_dist | (bsm_pkg::ROOT_W'(1) << b);
         trial_sq = 72'(trial) * 72'(trial);
         if (trial_sq <= dist_sq) root_dist = trial;
      end
      if (36'(root_dist) + 36'(p.r2) <= 36'(p.r1)) begin
         res.center = p.c1;
         res.radius = p.r1;
         res.mcase = bsm_pkg::CASE_FIRST;
      end else if (36'(root_dist) + 36'(p.r1) <= 36'(p.r2)) begin
         res.center = p.c2;
         res.radius = p.r2;
         res.mcase = bsm_pkg::CASE_SECOND;
      end else begin
         rad = (36'(root_dist) + 36'(p.r1) + 36'(p.r2)) >> 1;
         span_num = 36'(root_dist) + 36'(p.r2) - 36'(p.r1);
         span_den = 36'(root_dist) << 1;
         for (int a = 0; a < bsm_pkg::AXES; a++) begin
            mag = dc[a][bsm_pkg::COORD_W] ? -dc[a] : dc[a];
            offset = (72'(mag) * 72'(span_num)) / 72'(span_den);
            res.center[a] = dc[a][bsm_pkg::COORD_W] ?
                            p.c1[a] - offset[bsm_pkg::COORD_W-1:0] :
                            p.c1[a] + offset[bsm_pkg::COORD_W-1:0];
         end
         if (rad > 36'(bsm_pkg::RADIUS_MAX)) begin
            res.radius = bsm_pkg::RADIUS_MAX;
            res.mcase = bsm_pkg::CASE_SAT;
         end else begin
            res.radius = rad[bsm_pkg::RADIUS_W-1:0];
            res.mcase = bsm_pkg::CASE_GENERAL;
         end
      end
      return res;
   endfunction

   // Field-by-field identity, X and Z included.
   function automatic bit same_sphere(input enclosing_type a, input enclosing_type b);
      bit same;
      same = (a.radius === b.radius) && (a.mcase === b.mcase);
      for (int i = 0; i < bsm_pkg::AXES; i++) begin
         if (a.center[i] !== b.center[i]) same = 1'b0;
      end
      return same;
   endfunction

   function automatic sphere_pair_type make_pair(input logic signed [bsm_pkg::COORD_W-1:0] a,
                                                 input logic signed [bsm_pkg::COORD_W-1:0] b,
                                                 input int ra,
                                                 input int rb);
      sphere_pair_type p;
      for (int i = 0; i < bsm_pkg::AXES; i++) begin
         p.c1[i] = a;
         p.c2[i] = b;
      end
      p.r1 = bsm_pkg::RADIUS_W'(ra);
      p.r2 = bsm_pkg::RADIUS_W'(rb);
      return p;
   endfunction

   function automatic void add_row(input sphere_pair_type p, input bit known,
                                   input logic signed [bsm_pkg::COORD_W-1:0] cen,
                                   input int rad,
                                   input logic [bsm_pkg::CASE_W-1:0] mcase);
      directed_row_type row;
      row.pair = p;
      row.known = known;
      for (int i = 0; i < bsm_pkg::AXES; i++) row.sphere.center[i] = cen;
      row.sphere.radius = bsm_pkg::RADIUS_W'(rad);
      row.sphere.mcase = mcase;
      directed_rows.push_back(row);
   endfunction

   // Random pair, shaped to reach every case and both ends of the radius range.
   function automatic sphere_pair_type random_pair();
      sphere_pair_type p;
      int kind;
      int spread;
      kind = $urandom_range(0, 9);
      spread = $urandom_range(4, 31);
      for (int i = 0; i < bsm_pkg::AXES; i++) begin
         p.c1[i] = $urandom();
         if (kind < 3) p.c2[i] = $urandom();
         else if (kind == 3) p.c2[i] = p.c1[i];
         else p.c2[i] = p.c1[i] + ($signed($urandom()) >>> (31 - spread + 1));
      end
      case (kind)
         0, 1: begin
            p.r1 = bsm_pkg::RADIUS_W'($urandom());
            p.r2 = bsm_pkg::RADIUS_W'($urandom());
         end
         2: begin
            p.r1 = bsm_pkg::RADIUS_MAX - bsm_pkg::RADIUS_W'($urandom_range(0, 65535));
            p.r2 = bsm_pkg::RADIUS_MAX - bsm_pkg::RADIUS_W'($urandom_range(0, 65535));
         end
         default: begin
            p.r1 = bsm_pkg::RADIUS_W'($urandom() >> (31 - spread + $urandom_range(0, 2)));
            p.r2 = bsm_pkg::RADIUS_W'($urandom() >> (31 - spread + $urandom_range(0, 2)));
         end
      endcase
      return p;
   endfunction

   function automatic void report_mismatch(input enclosing_type want, input enclosing_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch: expected c=(%0d,%0d,%0d) r=%0d case=%0d, %s",
                  want.center[0], want.center[1], want.center[2], want.radius, want.mcase,
                  $sformatf("got c=(%0d,%0d,%0d) r=%0d case=%0d",
                            got.center[0], got.center[1], got.center[2], got.radius,
                            got.mcase));
   endfunction

   // Record each accepted pair and check each accepted sphere in order.
   always @(posedge clock) begin
      enclosing_type got;
      enclosing_type want;
      sphere_pair_type p;
      if (!reset && req_chan.valid && req_chan.ready) begin
         p.c1[0] = req_chan.first_center_x;
         p.c1[1] = req_chan.first_center_y;
         p.c1[2] = req_chan.first_center_z;
         p.c2[0] = req_chan.second_center_x;
         p.c2[1] = req_chan.second_center_y;
         p.c2[2] = req_chan.second_center_z;
         p.r1 = req_chan.first_radius;
         p.r2 = req_chan.second_radius;
         expected_spheres.push_back(merge_spheres(p));
         pairs_accepted++;
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.center[0] = rsp_chan.merged_center_x;
         got.center[1] = rsp_chan.merged_center_y;
         got.center[2] = rsp_chan.merged_center_z;
         got.radius = rsp_chan.merged_radius;
         got.mcase = rsp_chan.merge_case;
         if (expected_spheres.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("mismatch: sphere arrived with none expected");
         end else begin
            want = expected_spheres.pop_front();
            if (!same_sphere(want, got)) report_mismatch(want, got);
            case_seen[got.mcase]++;
         end
         spheres_checked++;
      end
   end

   // Result side: random stalls, one long hold-off that backs the pipeline up.
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_requested) begin
            hold_requested = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         stall = no_idle ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         while (!(rsp_chan.valid && rsp_chan.ready)) @(posedge clock);
      end
   end

   // Drive one pair and hold it until the core takes it.
   task automatic send_pair(input sphere_pair_type p);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.first_center_x <= p.c1[0];
      req_chan.first_center_y <= p.c1[1];
      req_chan.first_center_z <= p.c1[2];
      req_chan.second_center_x <= p.c2[0];
      req_chan.second_center_y <= p.c2[1];
      req_chan.second_center_z <= p.c2[2];
      req_chan.first_radius <= p.r1;
      req_chan.second_radius <= p.r2;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Reset, directed table, random pairs, drain and verdict.
   initial begin
      int drain;
      sphere_pair_type p;
      enclosing_type want;
      mismatch_count = 0;
      pairs_accepted = 0;
      spheres_checked = 0;
      hold_requested = 1'b0;
      no_idle = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.first_center_x = '0;
      req_chan.first_center_y = '0;
      req_chan.first_center_z = '0;
      req_chan.second_center_x = '0;
      req_chan.second_center_y = '0;
      req_chan.second_center_z = '0;
      req_chan.first_radius = '0;
      req_chan.second_radius = '0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Two identical spheres: the first is taken.
      add_row(make_pair(0, 0, 0, 0), 1, 0, 0, bsm_pkg::CASE_FIRST);
      add_row(make_pair(32'sh7fffffff, 32'sh7fffffff, int'(bsm_pkg::RADIUS_MAX),
                        int'(bsm_pkg::RADIUS_MAX)), 1,
              32'sh7fffffff, int'(bsm_pkg::RADIUS_MAX), bsm_pkg::CASE_FIRST);
      // Coinciding centers with the second radius larger.
      add_row(make_pair(-32'sh80000000, -32'sh80000000, 5, int'(bsm_pkg::RADIUS_MAX)), 1,
              -32'sh80000000, int'(bsm_pkg::RADIUS_MAX), bsm_pkg::CASE_SECOND);
      add_row(make_pair(1000, 1000, 1, 2), 1, 1000, 2, bsm_pkg::CASE_SECOND);
      // Each sphere containing the other at a distance.
      add_row(make_pair(0, 100, 1000, 10), 1, 0, 1000, bsm_pkg::CASE_FIRST);
      add_row(make_pair(0, 100, 10, 1000), 1, 100, 1000, bsm_pkg::CASE_SECOND);
      // Opposite corners of the coordinate range, with small and huge radii.
      add_row(make_pair(-32'sh80000000, 32'sh7fffffff, 0, 0), 0, 0, 0, bsm_pkg::CASE_GENERAL);
      add_row(make_pair(32'sh7fffffff, -32'sh80000000, 0, 1), 0, 0, 0, bsm_pkg::CASE_GENERAL);
      add_row(make_pair(-32'sh80000000, 32'sh7fffffff, int'(bsm_pkg::RADIUS_MAX),
                        int'(bsm_pkg::RADIUS_MAX)), 0, 0, 0, bsm_pkg::CASE_SAT);
      add_row(make_pair(-32'sh80000000, 32'sh7fffffff, int'(bsm_pkg::RADIUS_MAX), 0), 0, 0, 0,
              bsm_pkg::CASE_SAT);
      // Ordinary merges and the boundary of containment.
      add_row(make_pair(0, 65536, 0, 0), 0, 0, 0, bsm_pkg::CASE_GENERAL);
      add_row(make_pair(-7, 7, 3, 4), 0, 0, 0, bsm_pkg::CASE_GENERAL);
      add_row(make_pair(0, 1, 10, 11), 0, 0, 0, bsm_pkg::CASE_GENERAL);
      add_row(make_pair(0, 3, 1, 0), 0, 0, 0, bsm_pkg::CASE_GENERAL);

      foreach (directed_rows[i]) begin
         send_pair(directed_rows[i].pair);
         if (directed_rows[i].known) begin
            p = directed_rows[i].pair;
            want = merge_spheres(p);
            if (!same_sphere(want, directed_rows[i].sphere))
               report_mismatch(directed_rows[i].sphere, want);
         end
      end

      // The long hold falls in a stretch without idle cycles so the core backs up.
      for (int n = 0; n < RANDOM_PAIRS; n++) begin
         no_idle = (n / 100) % 3 == 1;
         if (n == 120) hold_requested = 1'b1;
         send_pair(random_pair());
      end
      req_chan.valid <= 1'b0;

      drain = 0;
      while (expected_spheres.size() != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Merged %0d sphere pairs, %0d results checked.", pairs_accepted, spheres_checked);
      $display("Cases seen: general %0d, first %0d, second %0d, saturated %0d.",
               case_seen[0], case_seen[1], case_seen[2], case_seen[3]);
      if (mismatch_count == 0 && expected_spheres.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #10ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/bsm_pkg.sv
hw/rtl/bsm_req_if.sv
hw/rtl/bsm_rsp_if.sv
hw/rtl/bsm_queue.sv
hw/rtl/bsm_front.sv
hw/rtl/bsm_back.sv
hw/rtl/bounding_sphere_merge_core.sv
tb/sv/bounding_sphere_merge_core_tb.sv
